// ===== sv/srlcha_pkg.sv =====
// ----------------------------------------------------------------------------
// srlcha_pkg
// Shared widths, constants and types of the series RLC harmonic admittance
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package srlcha_pkg;

  // highest valid harmonic order
  localparam int MAX_ORDER = 64;

  // port widths
  localparam int ORD_W   = 7;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W   = 48;

  // datapath widths
  localparam int F_W     = 40;              // frequency, Q.16 Hz
  localparam int K_W     = 23;              // 2*pi as Q3.20
  localparam int FK_W    = F_W + K_W;       // frequency times 2*pi
  localparam int W_W     = 43;              // omega, Q.16 rad/s
  localparam int WH_W    = W_W - 32;        // upper slice of omega
  localparam int P_W     = W_W + CFG_W;     // omega times L or C
  localparam int XL_W    = P_W + 1 - 24;    // inductive reactance, Q.16 ohm
  localparam int X_W     = 64;              // reactance before the clamp
  localparam int XM_W    = 62;              // clamped reactance magnitude
  localparam int XH_W    = XM_W - 31;       // upper slice of the magnitude
  localparam int DEN_W   = 125;             // divisor width
  localparam int NUM_W   = 126;             // dividend width
  localparam int Q_W     = 63;              // quotient width
  localparam int EXT_W   = DEN_W + Q_W;     // width of a shifted divisor
  localparam int DIV_LAT = Q_W + 1;         // number of divider register stages

  // constants
  localparam logic [K_W-1:0]   TWO_PI_Q20 = 23'd6588397;
  localparam logic [NUM_W-1:0] MEGA_Q48   = NUM_W'(20'd1000000) << 48;
  localparam logic [X_W-1:0]   X_LIMIT    = X_W'({XM_W{1'b1}});
  localparam logic [X_W-1:0]   XC_OPEN    = X_W'(1) << Q_W;
  localparam logic [Q_W-1:0]   POS_LIMIT  = Q_W'({(OUT_W-1){1'b1}});
  localparam logic [Q_W-1:0]   NEG_MAG    = Q_W'(1) << (OUT_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDUCTANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITANCE = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_START_FREQ  = 32'd3276800;
  localparam logic [CFG_W-1:0] RST_FREQ_STEP   = 32'd3276800;
  localparam logic [CFG_W-1:0] RST_RESISTANCE  = 32'd65536;
  localparam logic [CFG_W-1:0] RST_INDUCTANCE  = 32'd0;
  localparam logic [CFG_W-1:0] RST_CAPACITANCE = 32'd0;

  // divider result: saturation marks a quotient of 2^Q_W or more
  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

// ===== sv/srlcha_div.sv =====
// ----------------------------------------------------------------------------
// srlcha_div
// Pipelined restoring divider, one quotient bit per stage, with a front
// stage that flags quotients too large for the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module srlcha_div (
  input  wire                           clk,
  input  wire                           en,
  input  wire [srlcha_pkg::NUM_W-1:0]   num,
  input  wire [srlcha_pkg::DEN_W-1:0]   den,
  output srlcha_pkg::div_res_t          res
);

  localparam int NW = srlcha_pkg::NUM_W;
  localparam int DW = srlcha_pkg::DEN_W;
  localparam int QW = srlcha_pkg::Q_W;
  localparam int EW = srlcha_pkg::EXT_W;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW+1];
  logic          sat_r [QW+1];

  logic          sat_nxt;

  // flag a dividend at or above den * 2^QW
  assign sat_nxt = EW'(num) >= (EW'(den) << QW);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      sat_r[0] <= sat_nxt;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int SHIFT = QW - k;
    logic [EW-1:0] dsh;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    always_comb begin
      dsh     = EW'(den_r[k-1]) << SHIFT;
      ge      = EW'(rem_r[k-1]) >= dsh;
      rem_nxt = ge ? NW'(EW'(rem_r[k-1]) - dsh) : rem_r[k-1];
      quo_nxt = quo_r[k-1] | (QW'(ge) << SHIFT);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_nxt;
        sat_r[k] <= sat_r[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign res.sat = sat_r[QW];
  assign res.quo = quo_r[QW];

endmodule

`default_nettype wire

// ===== sv/series_rlc_harmonic_admittance_top.sv =====
// ----------------------------------------------------------------------------
// series_rlc_harmonic_admittance_top
// Admittance G + jB of a series R-L-C branch at a selected harmonic order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_harmonic_order) takes a one-based
//   harmonic order. Result channel (out_valid/out_ready) returns signed
//   Q16.32 conductance and susceptance plus a fault flag for a bad order,
//   a zero denominator or a saturated part.
//   Configuration: write cfg_data to the register selected by cfg_index
//   while cfg_write_en is high; write only while the pipeline is empty.
//   Throughput: one transaction per cycle while no stall holds the pipeline.
//   Depth: a result reaches out_valid after passing through 138 register
//   stages: the two chained 64-stage dividers (capacitive reactance, then G
//   and B in parallel), nine multiply/add stages and the output register.
//   Reset: synchronous, active low; clears all valid bits and loads the
//   register defaults (50 Hz start, 50 Hz step, 1 ohm, no L, no C).
//   Stall: while the output holds a result that is not taken, the whole
//   pipeline freezes and in_ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module series_rlc_harmonic_admittance_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire [srlcha_pkg::ORD_W-1:0]         in_harmonic_order,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [srlcha_pkg::OUT_W-1:0] out_conductance,
  output logic signed [srlcha_pkg::OUT_W-1:0] out_susceptance,
  output logic                                out_fault_flag,
  input  wire                                 cfg_write_en,
  input  wire [srlcha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [srlcha_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW  = srlcha_pkg::CFG_W;
  localparam int LAT = srlcha_pkg::DIV_LAT;

  typedef struct packed {
    logic                        bad;
    logic [srlcha_pkg::XL_W-1:0] xl;
  } sb1_t;

  typedef struct packed {
    logic bad;
    logic dz;
    logic neg;
  } sb2_t;

  // configuration registers
  logic [CW-1:0] start_r, step_r, res_r, ind_r, cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= srlcha_pkg::RST_START_FREQ;
      step_r  <= srlcha_pkg::RST_FREQ_STEP;
      res_r   <= srlcha_pkg::RST_RESISTANCE;
      ind_r   <= srlcha_pkg::RST_INDUCTANCE;
      cap_r   <= srlcha_pkg::RST_CAPACITANCE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        srlcha_pkg::REG_START_FREQ:  start_r <= cfg_data;
        srlcha_pkg::REG_FREQ_STEP:   step_r  <= cfg_data;
        srlcha_pkg::REG_RESISTANCE:  res_r   <= cfg_data;
        srlcha_pkg::REG_INDUCTANCE:  ind_r   <= cfg_data;
        srlcha_pkg::REG_CAPACITANCE: cap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: move whenever the output slot is free or being taken
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic [LAT-1:0] vd1_r, vd2_r;

  // stage 1: frequency and order range check
  logic [srlcha_pkg::F_W-1:0] f1_nxt, f1_r;
  logic                       bad1_nxt, bad1_r;

  always_comb begin
    bad1_nxt = (in_harmonic_order == '0) || (int'(in_harmonic_order) > srlcha_pkg::MAX_ORDER);
    f1_nxt   = srlcha_pkg::F_W'(start_r)
             + srlcha_pkg::F_W'(in_harmonic_order - srlcha_pkg::ORD_W'(1))
             * srlcha_pkg::F_W'(step_r);
  end

  // stage 2: omega with rounding
  logic [srlcha_pkg::FK_W-1:0] fk;
  logic [srlcha_pkg::W_W-1:0]  w2_nxt, w2_r;
  logic                        bad2_r;

  always_comb begin
    fk     = srlcha_pkg::FK_W'(f1_r) * srlcha_pkg::FK_W'(srlcha_pkg::TWO_PI_Q20)
           + (srlcha_pkg::FK_W'(1) << 19);
    w2_nxt = srlcha_pkg::W_W'(fk >> 20);
  end

  // stage 3: partial products of omega with L and C
  logic [63:0]                     pll_nxt, plc_nxt, pll_r, plc_r;
  logic [srlcha_pkg::WH_W+CW-1:0]  phl_nxt, phc_nxt, phl_r, phc_r;
  logic                            bad3_r;

  always_comb begin
    pll_nxt = 64'(w2_r[31:0]) * 64'(ind_r);
    plc_nxt = 64'(w2_r[31:0]) * 64'(cap_r);
    phl_nxt = (srlcha_pkg::WH_W+CW)'(w2_r[srlcha_pkg::W_W-1:32])
            * (srlcha_pkg::WH_W+CW)'(ind_r);
    phc_nxt = (srlcha_pkg::WH_W+CW)'(w2_r[srlcha_pkg::W_W-1:32])
            * (srlcha_pkg::WH_W+CW)'(cap_r);
  end

  // stage 4: inductive reactance and omega*C
  logic [srlcha_pkg::P_W:0]     wl_sum;
  logic [srlcha_pkg::XL_W-1:0]  xl4_nxt, xl4_r;
  logic [srlcha_pkg::P_W-1:0]   p4_nxt, p4_r;
  logic                         bad4_r;

  always_comb begin
    wl_sum  = (srlcha_pkg::P_W+1)'(pll_r) + ((srlcha_pkg::P_W+1)'(phl_r) << 32)
            + ((srlcha_pkg::P_W+1)'(1) << 23);
    xl4_nxt = srlcha_pkg::XL_W'(wl_sum >> 24);
    p4_nxt  = srlcha_pkg::P_W'(plc_r) + (srlcha_pkg::P_W'(phc_r) << 32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r   <= f1_nxt;
      bad1_r <= bad1_nxt;
      w2_r   <= w2_nxt;
      bad2_r <= bad1_r;
      pll_r  <= pll_nxt;
      plc_r  <= plc_nxt;
      phl_r  <= phl_nxt;
      phc_r  <= phc_nxt;
      bad3_r <= bad2_r;
      xl4_r  <= xl4_nxt;
      p4_r   <= p4_nxt;
      bad4_r <= bad3_r;
    end
  end

  // capacitive reactance: 10^6 * 2^48 / (omega*C), rounded
  srlcha_pkg::div_res_t xc_res;

  srlcha_div u_div_xc (
    .clk (clk),
    .en  (en),
    .num (srlcha_pkg::MEGA_Q48 + srlcha_pkg::NUM_W'(p4_r >> 1)),
    .den (srlcha_pkg::DEN_W'(p4_r)),
    .res (xc_res)
  );

  // carry sideband alongside the first divider
  sb1_t sb1_r [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= '{bad: bad4_r, xl: xl4_r};
      for (int i = 1; i < LAT; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // stage 5: net reactance, sign and clamp
  logic [srlcha_pkg::X_W-1:0]  xc, xl_ext, x_diff;
  logic [srlcha_pkg::XM_W-1:0] xm5_nxt, xm5_r;
  logic                        neg5_nxt, neg5_r, bad5_r;

  always_comb begin
    if (cap_r == '0) begin
      xc = '0;
    end else if (xc_res.sat) begin
      xc = srlcha_pkg::XC_OPEN;
    end else begin
      xc = srlcha_pkg::X_W'(xc_res.quo);
    end
    xl_ext = srlcha_pkg::X_W'(sb1_r[LAT-1].xl);
    if (xl_ext >= xc) begin
      x_diff   = xl_ext - xc;
      neg5_nxt = 1'b0;
    end else begin
      x_diff   = xc - xl_ext;
      neg5_nxt = 1'b1;
    end
    xm5_nxt = (x_diff > srlcha_pkg::X_LIMIT) ? srlcha_pkg::XM_W'(srlcha_pkg::X_LIMIT)
                                             : srlcha_pkg::XM_W'(x_diff);
  end

  // stage 6: partial squares
  logic [61:0]                 aa6_r, ab6_r, bb6_r;
  logic [63:0]                 rr6_r;
  logic [srlcha_pkg::XM_W-1:0] xm6_r;
  logic                        neg6_r, bad6_r;

  // stage 7: two partial sums
  logic [srlcha_pkg::DEN_W-1:0] t1_7_r, t2_7_r;
  logic [srlcha_pkg::XM_W-1:0]  xm7_r;
  logic                         neg7_r, bad7_r;

  // stage 8: denominator
  logic [srlcha_pkg::DEN_W-1:0] d8_r;
  logic [srlcha_pkg::XM_W-1:0]  xm8_r;
  logic                         neg8_r, bad8_r;

  // stage 9: rounded dividends
  logic [srlcha_pkg::DEN_W-1:0] d9_r;
  logic [srlcha_pkg::NUM_W-1:0] ng9_r, nb9_r;
  logic                         dz9_r, neg9_r, bad9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xm5_r  <= xm5_nxt;
      neg5_r <= neg5_nxt;
      bad5_r <= sb1_r[LAT-1].bad;

      aa6_r  <= 62'(xm5_r[srlcha_pkg::XM_W-1:31]) * 62'(xm5_r[srlcha_pkg::XM_W-1:31]);
      ab6_r  <= 62'(xm5_r[srlcha_pkg::XM_W-1:31]) * 62'(xm5_r[30:0]);
      bb6_r  <= 62'(xm5_r[30:0]) * 62'(xm5_r[30:0]);
      rr6_r  <= 64'(res_r) * 64'(res_r);
      xm6_r  <= xm5_r;
      neg6_r <= neg5_r;
      bad6_r <= bad5_r;

      t1_7_r <= (srlcha_pkg::DEN_W'(aa6_r) << 62) + (srlcha_pkg::DEN_W'(ab6_r) << 32);
      t2_7_r <= srlcha_pkg::DEN_W'(bb6_r) + srlcha_pkg::DEN_W'(rr6_r);
      xm7_r  <= xm6_r;
      neg7_r <= neg6_r;
      bad7_r <= bad6_r;

      d8_r   <= t1_7_r + t2_7_r;
      xm8_r  <= xm7_r;
      neg8_r <= neg7_r;
      bad8_r <= bad7_r;

      d9_r   <= d8_r;
      ng9_r  <= (srlcha_pkg::NUM_W'(res_r) << 48) + srlcha_pkg::NUM_W'(d8_r >> 1);
      nb9_r  <= (srlcha_pkg::NUM_W'(xm8_r) << 48) + srlcha_pkg::NUM_W'(d8_r >> 1);
      dz9_r  <= (d8_r == '0);
      neg9_r <= neg8_r;
      bad9_r <= bad8_r;
    end
  end

  // conductance and susceptance magnitudes
  srlcha_pkg::div_res_t g_res, b_res;

  srlcha_div u_div_g (
    .clk (clk),
    .en  (en),
    .num (ng9_r),
    .den (d9_r),
    .res (g_res)
  );

  srlcha_div u_div_b (
    .clk (clk),
    .en  (en),
    .num (nb9_r),
    .den (d9_r),
    .res (b_res)
  );

  sb2_t sb2_r [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= '{bad: bad9_r, dz: dz9_r, neg: neg9_r};
      for (int i = 1; i < LAT; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // output stage: saturate, apply sign, override faults
  logic [srlcha_pkg::OUT_W-1:0] g_nxt, b_nxt;
  logic [srlcha_pkg::Q_W-1:0]   b_mag;
  logic                         fault_nxt, g_ovf, b_ovf;
  sb2_t                         sb2_last;

  always_comb begin
    sb2_last = sb2_r[LAT-1];
    g_ovf    = g_res.sat || (g_res.quo > srlcha_pkg::POS_LIMIT);
    g_nxt    = g_ovf ? srlcha_pkg::OUT_W'(srlcha_pkg::POS_LIMIT)
                     : srlcha_pkg::OUT_W'(g_res.quo);
    if (sb2_last.neg) begin
      b_ovf = b_res.sat || (b_res.quo > srlcha_pkg::POS_LIMIT);
      b_mag = b_ovf ? srlcha_pkg::POS_LIMIT : b_res.quo;
      b_nxt = srlcha_pkg::OUT_W'(b_mag);
    end else begin
      b_ovf = b_res.sat || (b_res.quo > srlcha_pkg::NEG_MAG);
      b_mag = b_ovf ? srlcha_pkg::NEG_MAG : b_res.quo;
      b_nxt = srlcha_pkg::OUT_W'(0) - srlcha_pkg::OUT_W'(b_mag);
    end
    fault_nxt = g_ovf || b_ovf;
    if (sb2_last.bad || sb2_last.dz) begin
      g_nxt     = '0;
      b_nxt     = '0;
      fault_nxt = 1'b1;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vd1_r       <= '0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      vd2_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vd1_r       <= {vd1_r[LAT-2:0], v4_r};
      v5_r        <= vd1_r[LAT-1];
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      vd2_r       <= {vd2_r[LAT-2:0], v9_r};
      out_valid_r <= vd2_r[LAT-1];
    end
  end

  // output register
  logic [srlcha_pkg::OUT_W-1:0] g_out_r, b_out_r;
  logic                         fault_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g_out_r     <= g_nxt;
      b_out_r     <= b_nxt;
      fault_out_r <= fault_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_conductance = signed'(g_out_r);
  assign out_susceptance = signed'(b_out_r);
  assign out_fault_flag  = fault_out_r;

endmodule

`default_nettype wire
